// ===== design/hci_h4_receive_deframer_top_defines.svh =====
// Assertion macros shared by the deframer modules.
// Each macro is empty when SYNTH is defined.
`ifndef HCI_H4_RECEIVE_DEFRAMER_TOP_DEFINES_SVH
`define HCI_H4_RECEIVE_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
`define H4RX_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("h4rx: implication check failed");
`define H4RX_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("h4rx: forbidden condition seen");
`else
`define H4RX_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define H4RX_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== design/h4rx_pkg.sv =====
package h4rx_pkg;

    localparam int HDR_MAX = 4;
    localparam int CNT_W   = $clog2(HDR_MAX + 1);

    // H:4 packet type bytes.
    localparam logic [7:0] TYPE_ACL = 8'h02;
    localparam logic [7:0] TYPE_EVT = 8'h04;
    localparam logic [7:0] TYPE_ISO = 8'h05;

    // Event codes that matter to the deframer.
    localparam logic [7:0] EVT_LE_META      = 8'h3E;
    localparam logic [7:0] EVT_INQ_RESULT   = 8'h22;
    localparam logic [7:0] EVT_INQ_EXT      = 8'h2F;
    localparam logic [7:0] SUB_ADV_REPORT   = 8'h02;
    localparam logic [7:0] SUB_EXT_ADV_REPT = 8'h0D;

    // Packet kinds.
    localparam logic [1:0] KIND_EVT = 2'd0;
    localparam logic [1:0] KIND_ACL = 2'd1;
    localparam logic [1:0] KIND_ISO = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] packet_kind;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       may_discard;
        logic [1:0] status;
        logic       run_end;
    } res_t;

    typedef struct packed {
        res_t [HDR_MAX-1:0] ent;
        logic [CNT_W-1:0]   cnt;
    } burst_t;

endpackage

// ===== design/h4rx_core.sv =====
`include "hci_h4_receive_deframer_top_defines.svh"

module h4rx_core
    import h4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        take,
    input  logic        iso_enable,
    input  logic        classic_enable,
    input  logic [15:0] max_payload,
    output burst_t      burst
);

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  need_reg, need_next;
    logic [2:0]  got_reg, got_next;
    logic [15:0] left_reg, left_next;
    logic        disc_reg, disc_next;
    logic        first_reg, first_next;
    logic [7:0]  hdr_reg [3];
    logic [7:0]  hdr_next [3];

    logic        step;
    logic [7:0]  hdr_cur [HDR_MAX];
    logic [15:0] len;
    logic [15:0] left_dec;
    logic [7:0]  evt_len;

    assign step = in_valid && take;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        need_next  = need_reg;
        got_next   = got_reg;
        left_next  = left_reg;
        disc_next  = disc_reg;
        first_next = first_reg;
        burst      = '0;
        len        = '0;
        evt_len    = '0;
        left_dec   = (left_reg == 16'd0) ? 16'd0 : left_reg - 16'd1;

        for (int i = 0; i < 3; i++)
        begin
            hdr_cur[i] = hdr_reg[i];
        end
        hdr_cur[HDR_MAX-1]   = in_byte;
        hdr_cur[got_reg[1:0]] = in_byte;
        for (int i = 0; i < 3; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end

        unique case (phase_reg)
            PH_TYPE:
            begin
                if (in_byte == TYPE_EVT || in_byte == TYPE_ACL ||
                    (in_byte == TYPE_ISO && iso_enable))
                begin
                    if (in_byte == TYPE_EVT)
                    begin
                        kind_next = KIND_EVT;
                        need_next = 3'd2;
                    end
                    else if (in_byte == TYPE_ACL)
                    begin
                        kind_next = KIND_ACL;
                        need_next = 3'd4;
                    end
                    else
                    begin
                        kind_next = KIND_ISO;
                        need_next = 3'd4;
                    end
                    got_next   = 3'd0;
                    disc_next  = 1'b0;
                    first_next = 1'b1;
                    phase_next = PH_HDR;
                end
                else
                begin
                    burst.cnt                = CNT_W'(1);
                    burst.ent[0].out_byte    = in_byte;
                    burst.ent[0].status      = ST_BAD_TYPE;
                    burst.ent[0].run_end     = 1'b1;
                end
            end

            PH_SKIP:
            begin
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end

            PH_PAY:
            begin
                burst.cnt                    = CNT_W'(1);
                burst.ent[0].out_byte        = in_byte;
                burst.ent[0].packet_kind     = kind_reg;
                burst.ent[0].first_of_packet = first_reg;
                burst.ent[0].last_of_packet  = (left_reg <= 16'd1);
                burst.ent[0].may_discard     = disc_reg;
                burst.ent[0].run_end         = 1'b1;
                first_next = 1'b0;
                left_next  = left_dec;
                if (left_dec == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end

            PH_HDR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hdr_next[i] = hdr_cur[i];
                end
                got_next = got_reg + 3'd1;
                if (kind_reg == KIND_EVT && got_next == 3'd1)
                begin
                    if (in_byte == EVT_LE_META)
                    begin
                        need_next = 3'd3;
                    end
                    else if (classic_enable &&
                             (in_byte == EVT_INQ_RESULT || in_byte == EVT_INQ_EXT))
                    begin
                        disc_next = 1'b1;
                    end
                end

                if (got_next >= need_next)
                begin
                    // Header complete: work out the payload length.
                    if (kind_reg == KIND_EVT)
                    begin
                        evt_len = hdr_cur[1];
                        if (need_next == 3'd3)
                        begin
                            // The sub-event byte counts in the event length.
                            evt_len = (hdr_cur[1] == 8'd0) ? 8'd0 : hdr_cur[1] - 8'd1;
                            if (hdr_cur[2] == SUB_ADV_REPORT ||
                                hdr_cur[2] == SUB_EXT_ADV_REPT)
                            begin
                                disc_next = 1'b1;
                            end
                        end
                        len = {8'd0, evt_len};
                    end
                    else if (kind_reg == KIND_ISO)
                    begin
                        len = {2'b00, hdr_cur[3][5:0], hdr_cur[2]};
                    end
                    else
                    begin
                        len = {hdr_cur[3], hdr_cur[2]};
                    end

                    first_next = 1'b0;
                    left_next  = len;
                    if (len > max_payload)
                    begin
                        burst.cnt                = CNT_W'(1);
                        burst.ent[0].out_byte    = in_byte;
                        burst.ent[0].packet_kind = kind_reg;
                        burst.ent[0].status      = ST_OVERSIZE;
                        burst.ent[0].run_end     = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        burst.cnt = CNT_W'(need_next);
                        for (int k = 0; k < HDR_MAX; k++)
                        begin
                            if (3'(k) < need_next)
                            begin
                                burst.ent[k].out_byte        = hdr_cur[k];
                                burst.ent[k].packet_kind     = kind_reg;
                                burst.ent[k].first_of_packet = (k == 0) ? first_reg : 1'b0;
                                burst.ent[k].last_of_packet  =
                                    (3'(k) == need_next - 3'd1) && (len == 16'd0);
                                burst.ent[k].may_discard     = disc_next;
                                burst.ent[k].status          = ST_OK;
                                burst.ent[k].run_end         = (3'(k) == need_next - 3'd1);
                            end
                        end
                        phase_next = (len == 16'd0) ? PH_TYPE : PH_PAY;
                    end
                end
            end

            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            kind_reg  <= KIND_EVT;
            need_reg  <= 3'd0;
            got_reg   <= 3'd0;
            left_reg  <= 16'd0;
            disc_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            need_reg  <= need_next;
            got_reg   <= got_next;
            left_reg  <= left_next;
            disc_reg  <= disc_next;
            first_reg <= first_next;
        end
    end

    // Header bytes are held without reset; each is written before it is read.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    `H4RX_ASSERT_IMPLY(a_len_nonzero, clk, rst_n,
        phase_reg == PH_PAY || phase_reg == PH_SKIP, left_reg != 16'd0)
    `H4RX_ASSERT_IMPLY(a_error_alone, clk, rst_n,
        step && burst.cnt != '0 && burst.ent[0].status != ST_OK, burst.cnt == CNT_W'(1))
    `H4RX_ASSERT_NEVER(a_got_bound, clk, rst_n, phase_reg == PH_HDR && got_reg >= need_reg)

endmodule

// ===== design/h4rx_outq.sv =====
`include "hci_h4_receive_deframer_top_defines.svh"

module h4rx_outq
    import h4rx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load_valid,
    output logic   load_ready,
    input  burst_t load_burst,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_res
);

    res_t [HDR_MAX-1:0] ent_reg, ent_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;
    logic               load;

    assign out_valid  = (cnt_reg != '0);
    assign out_res    = ent_reg[0];
    assign pop        = out_valid && out_ready;
    assign load_ready = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ready);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            ent_next = load_burst.ent;
            cnt_next = load_burst.cnt;
        end
        else if (pop)
        begin
            // Shift the burst down by one entry.
            for (int i = 0; i < HDR_MAX - 1; i++)
            begin
                ent_next[i] = ent_reg[i+1];
            end
            ent_next[HDR_MAX-1] = ent_reg[HDR_MAX-1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `H4RX_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_reg > CNT_W'(HDR_MAX))
    `H4RX_ASSERT_IMPLY(a_tail_ends_run, clk, rst_n,
        cnt_reg == CNT_W'(1), ent_reg[0].run_end)
    `H4RX_ASSERT_IMPLY(a_first_is_ok, clk, rst_n,
        out_valid && ent_reg[0].first_of_packet, ent_reg[0].status == ST_OK)

endmodule

// ===== design/hci_h4_receive_deframer_top.sv =====
// HCI H:4 receive deframer.
// Input channel (in_valid, in_ready, rx_byte) takes one received UART byte per
// transfer. Output channel (out_valid, out_ready and the result fields) gives one
// tagged packet byte or one error report per transfer; run_end marks the last
// result caused by a given input byte.
// An accepted byte is held in an input register, is decoded by the framing
// logic, and its results land in a four-entry burst register. The first result
// is offered once the byte has passed through the input register and been
// loaded into the burst register. While out_ready is high, the burst register
// drains one result per cycle; it takes a new burst only when empty or as its
// last result leaves, so a completed header holds the input back until its
// results drain, and with out_ready high every other byte sustains one transfer per cycle.
// When the receiver stalls, the burst register holds its results and the input
// register holds one more byte, after which in_ready drops.
// Reset clears the framing state to waiting for a type byte, empties the burst
// register and sets iso_enable = 0, classic_enable = 0, max_payload = 1024.
// Registers (APB, pready tied high): 0x0 iso_enable, 0x4 classic_enable,
// 0x8 max_payload. Write them only while no packet is in flight.

module hci_h4_receive_deframer_top
    import h4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  packet_kind,
    output logic        first_of_packet,
    output logic        last_of_packet,
    output logic        may_discard,
    output logic [1:0]  status,
    output logic        run_end
);

    localparam logic [1:0] REG_ISO     = 2'd0;
    localparam logic [1:0] REG_CLASSIC = 2'd1;
    localparam logic [1:0] REG_MAXPAY  = 2'd2;

    logic        iso_enable_reg;
    logic        classic_enable_reg;
    logic [15:0] max_payload_reg;
    logic        cfg_write;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        take;
    burst_t      burst;
    res_t        head;

    // Configuration port. Reads are combinational since pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_enable_reg     <= 1'b0;
            classic_enable_reg <= 1'b0;
            max_payload_reg    <= 16'd1024;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ISO:     iso_enable_reg     <= pwdata[0];
                REG_CLASSIC: classic_enable_reg <= pwdata[0];
                REG_MAXPAY:  max_payload_reg    <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ISO:     prdata = {31'd0, iso_enable_reg};
            REG_CLASSIC: prdata = {31'd0, classic_enable_reg};
            REG_MAXPAY:  prdata = {16'd0, max_payload_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Input register: refilled whenever its byte moves on to the decoder.
    assign in_ready      = !in_valid_reg || take;
    assign in_valid_next = in_valid || (in_valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    h4rx_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid_reg),
        .in_byte        (in_byte_reg),
        .take           (take),
        .iso_enable     (iso_enable_reg),
        .classic_enable (classic_enable_reg),
        .max_payload    (max_payload_reg),
        .burst          (burst)
    );

    h4rx_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (take),
        .load_burst (burst),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (head)
    );

    assign out_byte        = head.out_byte;
    assign packet_kind     = head.packet_kind;
    assign first_of_packet = head.first_of_packet;
    assign last_of_packet  = head.last_of_packet;
    assign may_discard     = head.may_discard;
    assign status          = head.status;
    assign run_end         = head.run_end;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the HCI H:4 receive deframer.
//
// A stream of UART bytes is pushed through the input channel while the
// testbench runs its own model of the framing logic. The model keeps its own
// copy of the framing state and of the three configuration registers. For
// every accepted input transfer it appends the tagged results that byte must
// produce to a queue. A checking process pops the oldest entry on every
// output transfer and compares it field by field.
//
// The stimulus opens with short directed packets: unknown type bytes, plain
// events, LE meta events with and without advertising reports, inquiry
// reports with classic mode on and off, ACL and ISO packets, zero-length
// payloads, oversize packets and one long swallowed payload. After that come
// randomized packet streams under several register settings. The last stream
// runs with no idling on either side.

module tb;
    import h4rx_pkg::*;

    // Register byte addresses on the APB port.
    localparam logic [3:0] ADDR_ISO_ENABLE     = 4'h0;
    localparam logic [3:0] ADDR_CLASSIC_ENABLE = 4'h4;
    localparam logic [3:0] ADDR_MAX_PAYLOAD    = 4'h8;

    // A misframed random stream can open a packet of up to 65535 bytes. This
    // bound is several times what such a packet needs under the longest gaps.
    localparam int CYCLE_LIMIT = 6_000_000;

    // Cycles allowed after the last expected result before the block is
    // treated as quiet.
    localparam int SETTLE_CYCLES = 8;

    // Framing phases of the testbench model.
    typedef enum logic [1:0] {
        WAIT_TYPE,
        IN_HEADER,
        IN_PAYLOAD,
        SKIPPING
    } frame_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  packet_kind;
    logic        first_of_packet;
    logic        last_of_packet;
    logic        may_discard;
    logic [1:0]  status;
    logic        run_end;

    // Register mirror, updated when a write lands.
    logic        iso_en;
    logic        classic_en;
    logic [15:0] max_len;

    // Framing state of the model.
    frame_phase_t frame_phase;
    logic [1:0]   cur_kind;
    logic [7:0]   hdr_store [4];
    logic [2:0]   hdr_need;
    logic [2:0]   hdr_got;
    logic [15:0]  bytes_left;
    logic         discard_tag;
    logic         first_pending;

    // Results still owed by the block, oldest first.
    res_t pending_deframed [$];
    res_t head_result;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    hci_h4_receive_deframer_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .packet_kind     (packet_kind),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .may_discard     (may_discard),
        .status          (status),
        .run_end         (run_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung block must not keep the run going forever.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the framing logic
    // ------------------------------------------------------------------

    function automatic void push_result(input logic [7:0] b, input logic [1:0] kind,
                                        input logic first, input logic last,
                                        input logic disc, input logic [1:0] st,
                                        input logic fin);
        res_t r;
        r.out_byte        = b;
        r.packet_kind     = kind;
        r.first_of_packet = first;
        r.last_of_packet  = last;
        r.may_discard     = disc;
        r.status          = st;
        r.run_end         = fin;
        pending_deframed.push_back(r);
    endfunction

    function automatic void reset_model();
        iso_en        = 1'b0;
        classic_en    = 1'b0;
        max_len       = 16'd1024;
        frame_phase   = WAIT_TYPE;
        cur_kind      = KIND_EVT;
        hdr_need      = '0;
        hdr_got       = '0;
        bytes_left    = '0;
        discard_tag   = 1'b0;
        first_pending = 1'b0;
        foreach (hdr_store[i])
            hdr_store[i] = '0;
    endfunction

    // Works out the results one accepted UART byte causes and queues them.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [15:0] len;
        int k;
        case (frame_phase)
            WAIT_TYPE:
            begin
                if (b == TYPE_EVT)
                begin
                    cur_kind = KIND_EVT;
                    hdr_need = 3'd2;
                end
                else if (b == TYPE_ACL)
                begin
                    cur_kind = KIND_ACL;
                    hdr_need = 3'd4;
                end
                else if (b == TYPE_ISO && iso_en)
                begin
                    cur_kind = KIND_ISO;
                    hdr_need = 3'd4;
                end
                else
                begin
                    push_result(b, KIND_EVT, 1'b0, 1'b0, 1'b0, ST_BAD_TYPE, 1'b1);
                    return;
                end
                hdr_got       = '0;
                discard_tag   = 1'b0;
                first_pending = 1'b1;
                frame_phase   = IN_HEADER;
            end
            SKIPPING:
            begin
                if (bytes_left > 0)
                    bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0)
                    frame_phase = WAIT_TYPE;
            end
            IN_PAYLOAD:
            begin
                push_result(b, cur_kind, first_pending, bytes_left <= 16'd1, discard_tag,
                            ST_OK, 1'b1);
                first_pending = 1'b0;
                if (bytes_left > 0)
                    bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0)
                    frame_phase = WAIT_TYPE;
            end
            default:
            begin
                hdr_store[hdr_got[1:0]] = b;
                hdr_got = hdr_got + 3'd1;
                // The event code decides the header size and the inquiry tag.
                if (cur_kind == KIND_EVT && hdr_got == 3'd1)
                begin
                    if (b == EVT_LE_META)
                        hdr_need = 3'd3;
                    else if (classic_en && (b == EVT_INQ_RESULT || b == EVT_INQ_EXT))
                        discard_tag = 1'b1;
                end
                if (hdr_got < hdr_need)
                    return;

                if (cur_kind == KIND_EVT)
                begin
                    len = {8'h00, hdr_store[1]};
                    if (hdr_need == 3'd3)
                    begin
                        // The sub-event byte counts toward the length; an
                        // empty length saturates instead of wrapping.
                        len = (len >= 16'd1) ? len - 16'd1 : 16'd0;
                        if (hdr_store[2] == SUB_ADV_REPORT || hdr_store[2] == SUB_EXT_ADV_REPT)
                            discard_tag = 1'b1;
                    end
                end
                else
                begin
                    len = {hdr_store[3], hdr_store[2]};
                    if (cur_kind == KIND_ISO)
                        len[15:14] = 2'b00;
                end

                if (len > max_len)
                begin
                    push_result(b, cur_kind, 1'b0, 1'b0, 1'b0, ST_OVERSIZE, 1'b1);
                    bytes_left    = len;
                    frame_phase   = SKIPPING;
                    first_pending = 1'b0;
                    return;
                end

                for (k = 0; k < int'(hdr_need); k++)
                begin
                    push_result(hdr_store[k], cur_kind, (k == 0) ? first_pending : 1'b0,
                                (k == int'(hdr_need) - 1) && (len == 0), discard_tag, ST_OK,
                                k == int'(hdr_need) - 1);
                end
                first_pending = 1'b0;
                bytes_left    = len;
                frame_phase   = (len == 0) ? WAIT_TYPE : IN_PAYLOAD;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver stalls and result checking
    // ------------------------------------------------------------------

    // The receiver stalls in random bursts while idling is enabled.
    always @(negedge clk)
    begin
        if (idle_on && stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 19) - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every output transfer is matched against the oldest queued result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_deframed.size() == 0)
            begin
                $error("result with none expected: out_byte 0x%0h status %0d",
                       out_byte, status);
                mismatch_count++;
            end
            else
            begin
                head_result = pending_deframed.pop_front();
                check_field("out_byte", head_result.out_byte, out_byte);
                check_field("packet_kind", 8'(head_result.packet_kind), 8'(packet_kind));
                check_field("first_of_packet", 8'(head_result.first_of_packet),
                            8'(first_of_packet));
                check_field("last_of_packet", 8'(head_result.last_of_packet),
                            8'(last_of_packet));
                check_field("may_discard", 8'(head_result.may_discard), 8'(may_discard));
                check_field("status", 8'(head_result.status), 8'(status));
                check_field("run_end", 8'(head_result.run_end), 8'(run_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side and configuration
    // ------------------------------------------------------------------

    // Sends one UART byte. The task is entered and left just after a falling
    // edge; in_valid is left high so that back-to-back bytes keep it high.
    task automatic send_uart_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] frame [$]);
        foreach (frame[i])
            send_uart_byte(frame[i]);
    endtask

    // Drops in_valid, waits for every owed result and then lets the block
    // finish any byte that produces no result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_deframed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register writes happen only with the block idle and between packets.
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (addr)
            ADDR_ISO_ENABLE:     iso_en = data[0];
            ADDR_CLASSIC_ENABLE: classic_en = data[0];
            ADDR_MAX_PAYLOAD:    max_len = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Feeds filler until the model is back to waiting for a type byte.
    // Zero header bytes give an empty payload; payload and skipped bytes
    // are random.
    task automatic close_open_packet();
        while (frame_phase != WAIT_TYPE)
        begin
            if (frame_phase == IN_HEADER)
                send_uart_byte(8'h00);
            else
                send_uart_byte(8'($urandom));
        end
    endtask

    // One random packet: mostly well formed, sometimes a stray byte, a
    // truncated payload or an event header cut short.
    task automatic send_random_packet();
        logic [7:0]  frame [$];
        logic [7:0]  code;
        logic [7:0]  noise;
        logic [15:0] plen;
        int          pick;
        bit          cut;
        pick = $urandom_range(0, 11);
        cut  = ($urandom_range(0, 9) == 0);
        plen = '0;
        case (pick)
            0, 1:
            begin
                // A stray byte that is not a valid type here.
                noise = 8'($urandom);
                if (noise == TYPE_EVT || noise == TYPE_ACL || (noise == TYPE_ISO && iso_en))
                    noise = noise ^ 8'h80;
                frame.push_back(noise);
            end
            2, 3, 4:
            begin
                case ($urandom_range(0, 5))
                    0, 1: code = EVT_LE_META;
                    2:    code = EVT_INQ_RESULT;
                    3:    code = EVT_INQ_EXT;
                    default: code = 8'($urandom);
                endcase
                frame.push_back(TYPE_EVT);
                frame.push_back(code);
                if (code == EVT_LE_META)
                begin
                    plen = 16'($urandom_range(0, 10));
                    frame.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'(plen + 1));
                    if (frame[2] == 8'h00)
                        plen = '0;
                    case ($urandom_range(0, 2))
                        0: frame.push_back(SUB_ADV_REPORT);
                        1: frame.push_back(SUB_EXT_ADV_REPT);
                        default: frame.push_back(8'($urandom));
                    endcase
                end
                else
                begin
                    plen = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 255))
                                                        : 16'($urandom_range(0, 12));
                    frame.push_back(plen[7:0]);
                end
            end
            5, 6, 7:
            begin
                plen = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 300))
                                                    : 16'($urandom_range(0, 12));
                frame.push_back(TYPE_ACL);
                frame.push_back(8'($urandom));
                frame.push_back(8'($urandom));
                frame.push_back(plen[7:0]);
                frame.push_back(plen[15:8]);
            end
            8, 9:
            begin
                frame.push_back(TYPE_ISO);
                if (iso_en)
                begin
                    plen = 16'($urandom_range(0, 12));
                    frame.push_back(8'($urandom));
                    frame.push_back(8'($urandom));
                    frame.push_back(plen[7:0]);
                    // Only the low 14 bits of the ISO length count.
                    frame.push_back({2'($urandom), plen[13:8]});
                end
            end
            default:
            begin
                // Event header cut after the event code; the next packet's
                // type byte becomes the length.
                code = 8'($urandom);
                if (code == EVT_LE_META)
                    code = 8'h0E;
                frame.push_back(TYPE_EVT);
                frame.push_back(code);
            end
        endcase
        for (int i = 0; i < int'(plen); i++)
            frame.push_back(8'($urandom));
        if (cut && plen > 0)
            repeat ($urandom_range(1, int'(plen))) void'(frame.pop_back());
        send_frame(frame);
    endtask

    task automatic send_random_stream(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_packet();
        close_open_packet();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_unknown_types();
        // ISO is still disabled after reset, so its type byte is unknown too.
        send_frame('{8'h00, 8'hFF, TYPE_ISO, 8'h01, 8'h03, 8'h7F});
        wait_idle();
    endtask

    task automatic test_plain_events();
        send_frame('{TYPE_EVT, 8'h0E, 8'h02, 8'h00, 8'hFF});
        // A zero-length payload closes the packet on the last header byte.
        send_frame('{TYPE_EVT, 8'h0F, 8'h00});
        // Inquiry results are not discardable while classic mode is off.
        send_frame('{TYPE_EVT, EVT_INQ_RESULT, 8'h01, 8'hAA});
        wait_idle();
    endtask

    task automatic test_le_meta_events();
        send_frame('{TYPE_EVT, EVT_LE_META, 8'h03, SUB_ADV_REPORT, 8'h11, 8'h22});
        // A zero event length saturates the payload length to zero.
        send_frame('{TYPE_EVT, EVT_LE_META, 8'h00, SUB_EXT_ADV_REPT});
        send_frame('{TYPE_EVT, EVT_LE_META, 8'h01, 8'h01});
        wait_idle();
    endtask

    task automatic test_inquiry_reports();
        reg_write(ADDR_CLASSIC_ENABLE, 32'd1);
        send_frame('{TYPE_EVT, EVT_INQ_RESULT, 8'h01, 8'h55});
        send_frame('{TYPE_EVT, EVT_INQ_EXT, 8'h00});
        send_frame('{TYPE_EVT, EVT_LE_META, 8'h02, SUB_ADV_REPORT, 8'h80});
        reg_write(ADDR_CLASSIC_ENABLE, 32'd0);
    endtask

    task automatic test_acl_iso();
        send_frame('{TYPE_ACL, 8'hFF, 8'h0F, 8'h00, 8'h00});
        reg_write(ADDR_ISO_ENABLE, 32'd1);
        // The top two bits of the ISO length field are ignored.
        send_frame('{TYPE_ISO, 8'h01, 8'h20, 8'h02, 8'hC0, 8'hA5, 8'h5A});
        send_frame('{TYPE_ACL, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF});
        wait_idle();
    endtask

    task automatic test_oversize();
        reg_write(ADDR_MAX_PAYLOAD, 32'd3);
        send_frame('{TYPE_ACL, 8'h01, 8'h00, 8'h04, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04});
        send_frame('{TYPE_EVT, 8'h0E, 8'h03, 8'h10, 8'h20, 8'h30});
        send_frame('{TYPE_EVT, EVT_LE_META, 8'h05, SUB_ADV_REPORT, 8'h01, 8'h02, 8'h03,
                     8'h04});
        send_frame('{TYPE_ISO, 8'h02, 8'h00, 8'h04, 8'h40, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
        reg_write(ADDR_MAX_PAYLOAD, 32'd0);
        send_frame('{TYPE_EVT, 8'h0E, 8'h01, 8'h00});
        send_frame('{TYPE_EVT, 8'h0F, 8'h00});
        wait_idle();
    endtask

    task automatic test_long_skip();
        // A long payload just over the limit, swallowed byte by byte.
        reg_write(ADDR_MAX_PAYLOAD, 32'h003F);
        send_frame('{TYPE_ACL, 8'h00, 8'h00, 8'h40, 8'h00});
        repeat (64) send_uart_byte(8'($urandom));
        reg_write(ADDR_MAX_PAYLOAD, 32'hFFFF);
        send_frame('{TYPE_ACL, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'hFF, 8'h81});
        reg_write(ADDR_MAX_PAYLOAD, 32'd1024);
    endtask

    task automatic test_random_settings();
        for (int setting = 0; setting < 4; setting++)
        begin
            reg_write(ADDR_ISO_ENABLE, 32'($urandom_range(0, 1)));
            reg_write(ADDR_CLASSIC_ENABLE, 32'($urandom_range(0, 1)));
            case (setting)
                0: reg_write(ADDR_MAX_PAYLOAD, 32'd1024);
                1: reg_write(ADDR_MAX_PAYLOAD, 32'($urandom_range(0, 8)));
                2: reg_write(ADDR_MAX_PAYLOAD, 32'hFFFF);
                default: reg_write(ADDR_MAX_PAYLOAD, 32'($urandom_range(0, 65535)));
            endcase
            send_random_stream(50);
        end
        wait_idle();
    endtask

    task automatic test_back_to_back();
        reg_write(ADDR_ISO_ENABLE, 32'd1);
        reg_write(ADDR_CLASSIC_ENABLE, 32'd1);
        reg_write(ADDR_MAX_PAYLOAD, 32'd8);
        idle_on = 1'b0;
        send_random_stream(40);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unknown_types();
        test_plain_events();
        test_le_meta_events();
        test_inquiry_reports();
        test_acl_iso();
        test_oversize();
        test_long_skip();
        test_random_settings();
        test_back_to_back();

        wait_idle();
        if (mismatch_count == 0 && pending_deframed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/h4rx_pkg.sv
design/h4rx_core.sv
design/h4rx_outq.sv
design/hci_h4_receive_deframer_top.sv
verif/tb.sv
